// File: design/md4_pkg.sv
`default_nettype none
package md4_pkg;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_PREFETCH,
      ST_ROUND,
      ST_FOLD,
      ST_OUTPUT
   } state_type;

   // Where the compression takes its message words from
   typedef enum logic [1:0] {
      SRC_STORE,
      SRC_PAD_FIRST,
      SRC_PAD_LENGTH
   } src_type;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;
   localparam logic [31:0] K_ROUND2 = 32'h5a827999;
   localparam logic [31:0] K_ROUND3 = 32'h6ed9eba1;
   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LAST_STEP = 6'd47;
   localparam logic [5:0] LEN_FIELD_POS = 6'd56;

   // Message word index used by a step
   function automatic logic [3:0] msg_index(input logic [5:0] step);
      logic [3:0] j;
      begin
         j = step[3:0];
         case (step[5:4])
            2'd0: msg_index = j;
            2'd1: msg_index = {j[1:0], j[3:2]};
            default: msg_index = {j[0], j[1], j[2], j[3]};
         endcase
      end
   endfunction

   // Left rotation amount of a step
   function automatic logic [4:0] rot_amount(input logic [5:0] step);
      logic [3:0] sel;
      begin
         sel = {step[5:4], step[1:0]};
         case (sel)
            4'h0: rot_amount = 5'd3;
            4'h1: rot_amount = 5'd7;
            4'h2: rot_amount = 5'd11;
            4'h3: rot_amount = 5'd19;
            4'h4: rot_amount = 5'd3;
            4'h5: rot_amount = 5'd5;
            4'h6: rot_amount = 5'd9;
            4'h7: rot_amount = 5'd13;
            4'h8: rot_amount = 5'd3;
            4'h9: rot_amount = 5'd9;
            4'ha: rot_amount = 5'd11;
            4'hb: rot_amount = 5'd15;
            default: rot_amount = 5'd3;
         endcase
      end
   endfunction

endpackage
`default_nettype wire

// File: design/md4_if.sv
`default_nettype none
// Message channel
interface md4_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic [2:0]  byte_count;
   logic        end_of_message;
   modport source (output valid, data_word, byte_count, end_of_message, input ready);
   modport sink (input valid, data_word, byte_count, end_of_message, output ready);
endinterface

// Digest channel
interface md4_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic        last_word;
   modport source (output valid, digest_word, last_word, input ready);
   modport sink (input valid, digest_word, last_word, output ready);
endinterface
`default_nettype wire

// File: design/md4_hash_engine.sv
`default_nettype none
// Channel  Dir  Payload                                   Handshake
// req_if   in   data_word, byte_count, end_of_message     valid/ready
// rsp_if   out  digest_word, last_word                    valid/ready
//
// One item at a time: it is accepted in ST_IDLE, then ST_INSERT stores its valid bytes one by one and closes it.
// A full 64-byte block is compressed in order: one read prefetch, 48 steps fed by the
// block memory's single read port, one fold into the chaining value.
// The end item adds one or two such blocks, then four digest items.
// Synchronous active-high reset; no clearing pass. A stalled digest item holds.
module md4_hash_engine (
   input wire logic clock,
   input wire logic reset,
   md4_req_if.sink  req_if,
   md4_rsp_if.source rsp_if
);
   import md4_pkg::*;

   state_type   state_ff, state_in;
   src_type     src_ff, src_in;
   logic [31:0] word_ff;
   logic [2:0]  count_ff;
   logic        last_ff;
   logic [2:0]  k_ff;
   logic [60:0] len_ff;
   logic [31:0] cur_ff;
   logic [5:0]  step_ff;
   logic [1:0]  out_idx_ff;
   logic [31:0] chain_ff [4];
   logic [31:0] wv_ff [4];

   // block memory, one write and one read port
   logic [31:0] mem [16];
   logic [31:0] rdata_ff;
   logic [3:0]  rd_idx_ff;
   logic [3:0]  rd_addr;
   logic        rd_en;
   logic        wr_en;

   logic [5:0]  pos;
   logic [7:0]  in_byte;
   logic [31:0] cur_new;
   logic [31:0] pad_word;
   logic [31:0] blk_word;
   logic [31:0] f_val;
   logic [31:0] sum;
   logic [4:0]  rot;
   logic [31:0] t_val;
   logic [63:0] bit_len;

   assign pos = len_ff[5:0];
   assign bit_len = {len_ff, 3'b000};

   // byte k of the held item, merged into the partial word
   always_comb begin
      case (k_ff[1:0])
         2'd0: in_byte = word_ff[7:0];
         2'd1: in_byte = word_ff[15:8];
         2'd2: in_byte = word_ff[23:16];
         default: in_byte = word_ff[31:24];
      endcase
      cur_new = cur_ff;
      case (pos[1:0])
         2'd0: cur_new[7:0] = in_byte;
         2'd1: cur_new[15:8] = in_byte;
         2'd2: cur_new[23:16] = in_byte;
         default: cur_new[31:24] = in_byte;
      endcase
   end

   // partial word closed by the pad byte
   always_comb begin
      case (pos[1:0])
         2'd0: pad_word = {24'd0, PAD_BYTE};
         2'd1: pad_word = {16'd0, PAD_BYTE, cur_ff[7:0]};
         2'd2: pad_word = {8'd0, PAD_BYTE, cur_ff[15:0]};
         default: pad_word = {PAD_BYTE, cur_ff[23:0]};
      endcase
   end

   // message word seen by the current step
   always_comb begin
      blk_word = rdata_ff;
      if (src_ff == SRC_PAD_LENGTH) begin
         if (rd_idx_ff == 4'd14) blk_word = bit_len[31:0];
         else if (rd_idx_ff == 4'd15) blk_word = bit_len[63:32];
         else blk_word = '0;
      end else if (src_ff == SRC_PAD_FIRST) begin
         if (rd_idx_ff == pos[5:2]) blk_word = pad_word;
         else if (rd_idx_ff > pos[5:2]) begin
            if (pos < LEN_FIELD_POS && rd_idx_ff == 4'd14) blk_word = bit_len[31:0];
            else if (pos < LEN_FIELD_POS && rd_idx_ff == 4'd15) blk_word = bit_len[63:32];
            else blk_word = '0;
         end
      end
   end

   // one compression step
   always_comb begin
      case (step_ff[5:4])
         2'd0: f_val = wv_ff[3] ^ (wv_ff[1] & (wv_ff[2] ^ wv_ff[3]));
         2'd1: f_val = ((wv_ff[1] & wv_ff[2]) | (wv_ff[3] & (wv_ff[1] | wv_ff[2])))
                       + K_ROUND2;
         default: f_val = (wv_ff[1] ^ wv_ff[2] ^ wv_ff[3]) + K_ROUND3;
      endcase
      sum = wv_ff[0] + f_val + blk_word;
      rot = rot_amount(step_ff);
      t_val = (sum << rot) | (sum >> (6'd32 - {1'b0, rot}));
   end

   // next state and control
   always_comb begin
      state_in = state_ff;
      src_in = src_ff;
      rd_en = 1'b0;
      rd_addr = msg_index(6'd0);
      wr_en = 1'b0;
      req_if.ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) state_in = ST_INSERT;
         end
         ST_INSERT: begin
            if (k_ff == count_ff) begin
               if (last_ff) begin
                  src_in = SRC_PAD_FIRST;
                  state_in = ST_PREFETCH;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               wr_en = (pos[1:0] == 2'd3);
               if (pos == 6'd63) begin
                  src_in = SRC_STORE;
                  state_in = ST_PREFETCH;
               end
            end
         end
         ST_PREFETCH: begin
            rd_en = 1'b1;
            rd_addr = msg_index(6'd0);
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            rd_en = 1'b1;
            rd_addr = msg_index(step_ff + 6'd1);
            if (step_ff == LAST_STEP) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            case (src_ff)
               SRC_STORE: state_in = ST_INSERT;
               SRC_PAD_FIRST: begin
                  if (pos >= LEN_FIELD_POS) begin
                     src_in = SRC_PAD_LENGTH;
                     state_in = ST_PREFETCH;
                  end else begin
                     state_in = ST_OUTPUT;
                  end
               end
               default: state_in = ST_OUTPUT;
            endcase
         end
         ST_OUTPUT: begin
            if (rsp_if.ready && out_idx_ff == 2'd3) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_if.valid = (state_ff == ST_OUTPUT);
   assign rsp_if.digest_word = chain_ff[out_idx_ff];
   assign rsp_if.last_word = (out_idx_ff == 2'd3);

   // memory ports
   always_ff @(posedge clock) begin
      if (wr_en) mem[pos[5:2]] <= cur_new;
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
         rd_idx_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      src_ff <= src_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         src_ff <= SRC_STORE;
      end
   end

   // datapath and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         out_idx_ff <= '0;
         chain_ff[0] <= INIT_A;
         chain_ff[1] <= INIT_B;
         chain_ff[2] <= INIT_C;
         chain_ff[3] <= INIT_D;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_if.valid) begin
                  word_ff <= req_if.data_word;
                  count_ff <= (req_if.byte_count > 3'd4) ? 3'd4 : req_if.byte_count;
                  last_ff <= req_if.end_of_message;
                  k_ff <= '0;
               end
            end
            ST_INSERT: begin
               if (k_ff != count_ff) begin
                  cur_ff <= cur_new;
                  len_ff <= len_ff + 61'd1;
                  k_ff <= k_ff + 3'd1;
               end
            end
            ST_PREFETCH: begin
               step_ff <= '0;
               for (int i = 0; i < 4; i++) wv_ff[i] <= chain_ff[i];
            end
            ST_ROUND: begin
               step_ff <= step_ff + 6'd1;
               wv_ff[0] <= wv_ff[3];
               wv_ff[1] <= t_val;
               wv_ff[2] <= wv_ff[1];
               wv_ff[3] <= wv_ff[2];
            end
            ST_FOLD: begin
               for (int i = 0; i < 4; i++) chain_ff[i] <= chain_ff[i] + wv_ff[i];
               out_idx_ff <= '0;
            end
            ST_OUTPUT: begin
               if (rsp_if.ready) begin
                  out_idx_ff <= out_idx_ff + 2'd1;
                  if (out_idx_ff == 2'd3) begin
                     len_ff <= '0;
                     chain_ff[0] <= INIT_A;
                     chain_ff[1] <= INIT_B;
                     chain_ff[2] <= INIT_C;
                     chain_ff[3] <= INIT_D;
                  end
               end
            end
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire

// File: design/md4_checker.sv
`default_nettype none
module md4_props (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_digest_word,
   input wire logic        rsp_last_word
);

   // stalled digest item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word)
         && $stable(rsp_last_word))
      else $error("digest item changed while stalled");

   // no new message item is taken while a digest is being delivered
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input open during digest output");

   // nothing leaves right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("digest valid after reset");

   // final digest word closes the output burst
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_word |=> !rsp_valid)
      else $error("digest output ran past last word");

   // a message item starts work, so no item is taken in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken on consecutive cycles");

endmodule

bind md4_hash_engine md4_props u_md4_props (
   .clock(clock),
   .reset(reset),
   .req_valid(req_if.valid),
   .req_ready(req_if.ready),
   .rsp_valid(rsp_if.valid),
   .rsp_ready(rsp_if.ready),
   .rsp_digest_word(rsp_if.digest_word),
   .rsp_last_word(rsp_if.last_word)
);
`default_nettype wire

// File: verif/md4_checker.sv
module md4_checker (
   input  wire logic  clock,
   input  wire logic  reset,
   md4_req_if         req_mon,
   md4_rsp_if         rsp_mon,
   output int         error_count,
   output int         pending_count,
   output int         digest_count
);
   import md4_pkg::*;

   // predicted engine state
   logic [31:0] chain_q[4];
   logic [31:0] block_q[16];
   logic [60:0] byte_total;

   typedef struct packed {
      logic [31:0] digest_word;
      logic        last_word;
   } digest_item_type;

   digest_item_type digest_queue[$];

   function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
      return (x << s) | (x >> (32 - s));
   endfunction

   // one 48-step compression folded into chain_q
   task automatic md4_compress(input logic [31:0] blk[16]);
      logic [31:0] wa, wb, wc, wd, f, t;
      int rnd, j, idx, sh;
      wa = chain_q[0]; wb = chain_q[1]; wc = chain_q[2]; wd = chain_q[3];
      for (int i = 0; i < 48; i++) begin
         rnd = i / 16;
         j = i % 16;
         if (rnd == 0) begin
            f = wd ^ (wb & (wc ^ wd));
            idx = j;
            sh = (j % 4 == 0) ? 3 : (j % 4 == 1) ? 7 : (j % 4 == 2) ? 11 : 19;
         end else if (rnd == 1) begin
            f = ((wb & wc) | (wd & (wb | wc))) + K_ROUND2;
            idx = (j % 4) * 4 + j / 4;
            sh = (j % 4 == 0) ? 3 : (j % 4 == 1) ? 5 : (j % 4 == 2) ? 9 : 13;
         end else begin
            f = (wb ^ wc ^ wd) + K_ROUND3;
            idx = {j[0], j[1], j[2], j[3]};
            sh = (j % 4 == 0) ? 3 : (j % 4 == 1) ? 9 : (j % 4 == 2) ? 11 : 15;
         end
         t = rotl(wa + f + blk[idx], sh);
         wa = wd; wd = wc; wc = wb; wb = t;
      end
      chain_q[0] += wa; chain_q[1] += wb; chain_q[2] += wc; chain_q[3] += wd;
   endtask

   task automatic restart_message();
      chain_q[0] = INIT_A; chain_q[1] = INIT_B;
      chain_q[2] = INIT_C; chain_q[3] = INIT_D;
      foreach (block_q[i]) block_q[i] = '0;
      byte_total = '0;
   endtask

   task automatic set_byte(inout logic [31:0] blk[16], input int pos, input logic [7:0] b);
      blk[(pos / 4) % 16][(pos % 4) * 8 +: 8] = b;
   endtask

   // absorb one message item, pad and queue digest on the end marker
   task automatic absorb_item(input logic [31:0] word, input logic [2:0] cnt,
                              input logic eom);
      logic [31:0] pad[16];
      logic [63:0] bit_len;
      int n, pos;
      digest_item_type d;
      n = (cnt > 4) ? 4 : cnt;
      for (int k = 0; k < n; k++) begin
         pos = byte_total[5:0];
         set_byte(block_q, pos, word[8 * k +: 8]);
         byte_total = byte_total + 1;
         if (pos == 63) md4_compress(block_q);
      end
      if (eom) begin
         pos = byte_total[5:0];
         bit_len = {byte_total, 3'b000};
         pad = block_q;
         set_byte(pad, pos, PAD_BYTE);
         for (int p = pos + 1; p < 64; p++) set_byte(pad, p, 8'h00);
         if (pos >= LEN_FIELD_POS) begin
            md4_compress(pad);
            foreach (pad[i]) pad[i] = '0;
         end
         pad[14] = bit_len[31:0];
         pad[15] = bit_len[63:32];
         md4_compress(pad);
         for (int k = 0; k < 4; k++) begin
            d.digest_word = chain_q[k];
            d.last_word = (k == 3);
            digest_queue.push_back(d);
         end
         restart_message();
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   initial begin
      error_count = 0;
      digest_count = 0;
      pending_count = 0;
      restart_message();
   end

   // watch both channels at each edge
   always @(posedge clock) begin
      digest_item_type exp_item;
      if (reset) begin
         restart_message();
         digest_queue.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            digest_count++;
            if (digest_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected digest item %h", rsp_mon.digest_word));
            end else begin
               exp_item = digest_queue.pop_front();
               if (rsp_mon.digest_word !== exp_item.digest_word)
                  report_mismatch($sformatf("digest_word %h, want %h",
                     rsp_mon.digest_word, exp_item.digest_word));
               if (rsp_mon.last_word !== exp_item.last_word)
                  report_mismatch($sformatf("last_word %b, want %b",
                     rsp_mon.last_word, exp_item.last_word));
            end
         end
         if (req_mon.valid && req_mon.ready)
            absorb_item(req_mon.data_word, req_mon.byte_count, req_mon.end_of_message);
      end
      pending_count = digest_queue.size();
   end
endmodule

// File: verif/tb_top.sv
module tb_top;
   logic clock = 1'b0;
   logic reset = 1'b1;
   int   error_count, pending_count, digest_count;
   int   send_idle_pct = 23;
   int   recv_idle_pct = 69;
   bit   recv_hold = 1'b0;
   int   item_total = 0;

   md4_req_if req_if();
   md4_rsp_if rsp_if();

   md4_hash_engine i_dut (.clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if));

   md4_checker i_checker (
      .clock(clock), .reset(reset), .req_mon(req_if), .rsp_mon(rsp_if),
      .error_count(error_count), .pending_count(pending_count),
      .digest_count(digest_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.data_word = '0;
      req_if.byte_count = '0;
      req_if.end_of_message = 1'b0;
      rsp_if.ready = 1'b0;
   end

   // digest receiver with random stalls
   always @(posedge clock) begin
      if (reset || recv_hold)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // offer one message item and wait for acceptance
   task automatic send_item(input logic [31:0] word, input logic [2:0] cnt, input logic eom);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data_word <= word;
      req_if.byte_count <= cnt;
      req_if.end_of_message <= eom;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      item_total++;
   endtask

   task automatic drain_digests();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // random message: mostly full words, some short, rare odd counts
   task automatic send_message(input int words);
      logic [2:0] cnt;
      int r;
      for (int w = 0; w < words; w++) begin
         r = $urandom_range(99);
         cnt = (r < 75) ? 3'd4 : (r < 90) ? 3'($urandom_range(3)) : 3'($urandom_range(7, 5));
         send_item($urandom, (w == words - 1) ? 3'($urandom_range(7)) : cnt, w == words - 1);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty message, "abc", extremes, short and odd counts
      send_item(32'h0, 3'd0, 1'b1);
      send_item(32'h00636261, 3'd3, 1'b1);
      send_item(32'hffffffff, 3'd4, 1'b0);
      send_item(32'h00000000, 3'd0, 1'b0);
      send_item(32'h12345678, 3'd1, 1'b0);
      send_item(32'hdeadbeef, 3'd7, 1'b0);
      send_item(32'ha5a5a5a5, 3'd5, 1'b0);
      send_item(32'h5a5a5a5a, 3'd6, 1'b1);
      // 55 bytes then end: single pad block (56 bytes would need two blocks)
      for (int i = 0; i < 14; i++) send_item($urandom, (i == 13) ? 3'd3 : 3'd4, i == 13);
      drain_digests();

      // phase 1: receiver mostly idle
      while (item_total < 90) send_message($urandom_range(1, 20));
      drain_digests();

      // long receiver hold-off so the engine stalls on its digest output
      send_idle_pct = 0;
      recv_hold = 1'b1;
      fork
         repeat (400) @(posedge clock);
         begin
            send_message(3);
            send_message(3);
         end
      join_any
      recv_hold = 1'b0;
      wait fork;
      drain_digests();

      // phase 2: sender mostly idle; long message crossing several blocks
      send_idle_pct = 69;
      recv_idle_pct = 23;
      send_message(40);
      while (item_total < 160) send_message($urandom_range(1, 18));
      drain_digests();

      // phase 3: no idling
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (item_total < 210) send_message($urandom_range(1, 18));
      drain_digests();
      repeat (200) @(posedge clock);

      $display("covered %0d items and %0d digest words across empty, short, padded",
               item_total, digest_count);
      $display("and multi-block messages under three stall mixes");
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #5000000;
      $display("timeout at %0t", $realtime);
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule

// File: md4_hash_engine.f
design/md4_pkg.sv
design/md4_if.sv
design/md4_hash_engine.sv
design/md4_checker.sv
verif/md4_checker.sv
verif/tb_top.sv
